[design/sixteen_bit_cpu_execute_assert.svh]
// Assertion macros shared by the block's RTL.
`ifndef SIXTEEN_BIT_CPU_EXECUTE_ASSERT_SVH
`define SIXTEEN_BIT_CPU_EXECUTE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SBCE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SBCE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/sbce_pkg.sv]
package sbce_pkg;

   localparam int STORE_ENTRIES_DEF = 16;
   localparam int STACK_DEPTH_DEF   = 16;

   localparam logic [3:0] OP_CTRL  = 4'd0;
   localparam logic [3:0] OP_MOVE  = 4'd1;
   localparam logic [3:0] OP_STORE = 4'd2;
   localparam logic [3:0] OP_LOAD  = 4'd3;
   localparam logic [3:0] OP_ADD   = 4'd4;
   localparam logic [3:0] OP_SUB   = 4'd5;
   localparam logic [3:0] OP_MUL   = 4'd6;
   localparam logic [3:0] OP_AND   = 4'd7;
   localparam logic [3:0] OP_OR    = 4'd8;
   localparam logic [3:0] OP_NOT   = 4'd9;
   localparam logic [3:0] OP_XOR   = 4'd10;
   localparam logic [3:0] OP_SHR   = 4'd11;
   localparam logic [3:0] OP_SHL   = 4'd12;
   localparam logic [3:0] OP_ROR   = 4'd13;
   localparam logic [3:0] OP_ROL   = 4'd14;
   localparam logic [3:0] OP_HALT  = 4'd15;

   localparam logic [1:0] SUB_NOP  = 2'd0;
   localparam logic [1:0] SUB_PUSH = 2'd1;
   localparam logic [1:0] SUB_POP  = 2'd2;
   localparam logic [1:0] SUB_CMP  = 2'd3;

   // 8-bit immediate: codes above 127 fold to 255 minus the code
   function automatic logic [15:0] fold8(input logic [7:0] v);
      logic [7:0] r;
      r = v[7] ? (8'd255 - v) : v;
      return {8'd0, r};
   endfunction

   // shift count: above 15 becomes 31 minus it
   function automatic logic [3:0] shamt(input logic [4:0] s);
      return s[4] ? ~s[3:0] : s[3:0];
   endfunction

   // 9-bit jump offset, values above 255 mean 255 minus the value
   function automatic logic [15:0] jump_step(input logic [8:0] off);
      return off[8] ? (16'd255 - {7'd0, off}) : {7'd0, off};
   endfunction

endpackage

[design/sbce_ram.sv]
module sbce_ram #(
   parameter int W = 16,
   parameter int D = 16,
   localparam int AW = (D > 1) ? $clog2(D) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [W-1:0]  wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [W-1:0]  rd_data
);

   logic [W-1:0] mem [D];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[design/sixteen_bit_cpu_execute.sv]
// Flow: an accepted beat steps through RDM, RDN and EXEC to FIN, which offers the result;
//   pop adds POPWB, multiply adds MUL (16 shift-add steps), store/load add SCAN up to the
//   matching key, or over all keys held on a miss, and a load hit adds LDWB as well.
// Intake: a new beat is taken only in IDLE, after FIN; the next beat is taken while a
//   result waits. The key scan (one key per cycle) and the shift-add multiply hold it longest.
// Reset (synchronous, active high): registers, pc, flags, stack/store counts, halt clear.
module sixteen_bit_cpu_execute #(
   parameter int STORE_ENTRIES = sbce_pkg::STORE_ENTRIES_DEF,
   parameter int STACK_DEPTH   = sbce_pkg::STACK_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_instruction,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_next_pc,
   output logic        rsp_halted,
   output logic        rsp_reg_written,
   output logic [2:0]  rsp_reg_index,
   output logic [15:0] rsp_reg_value,
   output logic        rsp_flag_zero,
   output logic        rsp_flag_carry,
   output logic        rsp_flag_sign,
   output logic        rsp_flag_overflow,
   output logic        rsp_store_dropped,
   output logic        rsp_stack_fault
);
   import sbce_pkg::*;
   `include "sixteen_bit_cpu_execute_assert.svh"

   localparam int AW  = (STORE_ENTRIES > 1) ? $clog2(STORE_ENTRIES) : 1;
   localparam int CW  = $clog2(STORE_ENTRIES + 1);
   localparam int SAW = $clog2(STACK_DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE, ST_RDM, ST_RDN, ST_EXEC, ST_MUL, ST_SCAN, ST_LDWB, ST_POPWB, ST_FIN
   } state_type;

   state_type state_ff;
   state_type exec_next;             // state after the execute cycle

   // current instruction and its operands
   logic [15:0] instr_ff, rm_ff, rn_ff;
   logic [15:0] pc_ff;
   logic [3:0]  flags_ff;            // bit0 Z, bit1 C, bit2 S, bit3 Ov
   logic        halt_ff;
   logic [SAW-1:0] stk_cnt_ff;       // items on the stack
   logic [CW-1:0]  mem_cnt_ff;       // keys in the store
   // key scan: issue pointer, and the entry whose key is on the RAM output
   logic [CW-1:0]  iss_ff;
   logic           chk_vld_ff;
   logic [AW-1:0]  chk_idx_ff;
   // shift-add multiply
   logic [15:0] mul_acc_ff, mul_a_ff, mul_b_ff;
   logic [3:0]  mul_cnt_ff;
   // per-instruction result
   logic        res_wr_ff, res_drop_ff, res_fault_ff;
   logic [15:0] res_val_ff;
   // register file valid bits; unwritten registers read zero
   logic [7:0]  rf_vld_ff;
   logic        rf_rvld_ff;
   logic        rsp_valid_ff;

   logic [3:0] op, hi;
   logic [2:0] rd;
   logic [1:0] sub;
   assign op  = instr_ff[15:12];
   assign hi  = instr_ff[11:8];
   assign rd  = instr_ff[10:8];
   assign sub = instr_ff[1:0];

   // RAM ports
   logic [2:0]  rf_raddr;
   logic [15:0] rf_rdata, rf_wdata;
   logic        rf_we;
   logic        key_we, val_we, stk_we;
   logic [AW-1:0] key_waddr, val_waddr;
   logic [15:0] key_rdata, val_rdata, val_wdata, stk_rdata;
   logic [SAW-1:0] stk_raddr;

   // shared adder: add, sub, compare overflow and the multiply steps
   logic [15:0] add_a, add_b;
   logic        add_sub;
   logic [16:0] sum;

   always_comb begin
      add_a   = rm_ff;
      add_b   = rn_ff;
      add_sub = 1'b0;
      if (state_ff == ST_MUL) begin
         add_a = mul_acc_ff;
         add_b = mul_a_ff;
      end else if (op == OP_SUB) begin
         add_sub = 1'b1;
      end
   end
   assign sum = {1'b0, add_a} + {1'b0, add_sub ? ~add_b : add_b} + 17'(add_sub);

   logic [3:0]  sh;
   logic [15:0] alu_val, st_data, mul_res, step;
   logic        is_jump, take, key_hit, scan_miss, store_room;
   logic        push_op, pop_op, pop_ok;

   assign sh         = shamt(instr_ff[4:0]);
   assign st_data    = (hi < 4'd7) ? rn_ff : fold8({instr_ff[10:8], instr_ff[4:0]});
   assign mul_res    = mul_b_ff[0] ? sum[15:0] : mul_acc_ff;
   assign is_jump    = (op == OP_CTRL) && instr_ff[11];
   assign key_hit    = chk_vld_ff && (key_rdata == rm_ff);
   assign scan_miss  = !chk_vld_ff && (iss_ff == mem_cnt_ff);
   assign store_room = mem_cnt_ff < CW'(STORE_ENTRIES);
   assign push_op    = !halt_ff && (op == OP_CTRL) && !instr_ff[11] && (sub == SUB_PUSH);
   assign pop_op     = !halt_ff && (op == OP_CTRL) && !instr_ff[11] && (sub == SUB_POP);
   assign pop_ok     = (stk_cnt_ff != '0);

   always_comb begin
      case (sub)
         2'd0:    take = 1'b1;
         2'd1:    take = flags_ff[0] && !flags_ff[1];
         2'd2:    take = !flags_ff[0] && flags_ff[1];
         default: take = !flags_ff[0] && !flags_ff[1];
      endcase
   end

   always_comb begin
      if (halt_ff || op == OP_HALT) begin
         step = 16'd0;
      end else if (is_jump) begin
         step = take ? jump_step(instr_ff[10:2]) : 16'd2;
      end else begin
         step = 16'd2;
      end
   end

   always_comb begin
      case (op)
         OP_MOVE: alu_val = (hi < 4'd7) ? rm_ff : fold8(instr_ff[7:0]);
         OP_ADD:  alu_val = sum[15:0];
         OP_SUB:  alu_val = sum[15:0];
         OP_AND:  alu_val = rm_ff & rn_ff;
         OP_OR:   alu_val = rm_ff | rn_ff;
         OP_NOT:  alu_val = ~rm_ff;
         OP_XOR:  alu_val = rm_ff ^ rn_ff;
         OP_SHR:  alu_val = rm_ff >> sh;
         OP_SHL:  alu_val = rm_ff << sh;
         OP_ROR:  alu_val = {rm_ff[0], rm_ff[15:1]};
         OP_ROL:  alu_val = {rm_ff[14:0], rm_ff[15]};
         default: alu_val = 16'd0;
      endcase
   end

   // where the execute cycle goes next
   always_comb begin
      exec_next = ST_FIN;
      if (!halt_ff) begin
         case (op)
            OP_STORE, OP_LOAD: exec_next = ST_SCAN;
            OP_MUL:            exec_next = ST_MUL;
            OP_CTRL: begin
               if (pop_op && pop_ok) begin
                  exec_next = ST_POPWB;
               end
            end
            default: ;
         endcase
      end
   end

   // RAM control
   always_comb begin
      rf_raddr  = (state_ff == ST_IDLE) ? req_instruction[7:5] : instr_ff[4:2];
      rf_we     = 1'b0;
      rf_wdata  = alu_val;
      key_we    = 1'b0;
      val_we    = 1'b0;
      key_waddr = mem_cnt_ff[AW-1:0];
      val_waddr = mem_cnt_ff[AW-1:0];
      val_wdata = st_data;
      stk_we    = 1'b0;
      stk_raddr = stk_cnt_ff - SAW'(1);
      unique case (state_ff)
         ST_EXEC: begin
            if (!halt_ff) begin
               case (op)
                  OP_MOVE, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_NOT, OP_XOR,
                  OP_SHR, OP_SHL, OP_ROR, OP_ROL: rf_we = 1'b1;
                  OP_CTRL: stk_we = !instr_ff[11] && (sub == SUB_PUSH) &&
                                    (stk_cnt_ff != SAW'(STACK_DEPTH - 1));
                  default: ;
               endcase
            end
         end
         ST_MUL: begin
            rf_we    = (mul_cnt_ff == 4'd15);
            rf_wdata = mul_res;
         end
         ST_SCAN: begin
            if (op == OP_STORE) begin
               if (key_hit) begin
                  val_we    = 1'b1;
                  val_waddr = chk_idx_ff;
               end else if (scan_miss && store_room) begin
                  val_we = 1'b1;
                  key_we = 1'b1;
               end
            end
         end
         ST_LDWB: begin
            rf_we    = 1'b1;
            rf_wdata = val_rdata;
         end
         ST_POPWB: begin
            rf_we    = 1'b1;
            rf_wdata = stk_rdata;
         end
         default: ;
      endcase
   end

   sbce_ram #(.W(16), .D(8)) u_rf (
      .clock(clock), .wr_en(rf_we), .wr_addr(rd), .wr_data(rf_wdata),
      .rd_addr(rf_raddr), .rd_data(rf_rdata));

   sbce_ram #(.W(16), .D(STORE_ENTRIES)) u_keys (
      .clock(clock), .wr_en(key_we), .wr_addr(key_waddr), .wr_data(rm_ff),
      .rd_addr(iss_ff[AW-1:0]), .rd_data(key_rdata));

   sbce_ram #(.W(16), .D(STORE_ENTRIES)) u_vals (
      .clock(clock), .wr_en(val_we), .wr_addr(val_waddr), .wr_data(val_wdata),
      .rd_addr(chk_idx_ff), .rd_data(val_rdata));

   sbce_ram #(.W(16), .D(STACK_DEPTH)) u_stack (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_cnt_ff), .wr_data(rn_ff),
      .rd_addr(stk_raddr), .rd_data(stk_rdata));

   logic [15:0] rf_rval;
   assign rf_rval = rf_rvld_ff ? rf_rdata : 16'd0;

   always_ff @(posedge clock) begin
      rf_rvld_ff <= rf_vld_ff[rf_raddr];
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= 16'd0;
         flags_ff     <= 4'd0;
         halt_ff      <= 1'b0;
         stk_cnt_ff   <= '0;
         mem_cnt_ff   <= '0;
         rf_vld_ff    <= 8'd0;
         rsp_valid_ff <= 1'b0;
         chk_vld_ff   <= 1'b0;
      end else begin
         // FIN reloads the result register itself
         if (rsp_valid_ff && rsp_ready && state_ff != ST_FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         if (rf_we) begin
            rf_vld_ff[rd] <= 1'b1;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  instr_ff <= req_instruction;
                  state_ff <= ST_RDM;
               end
            end
            ST_RDM: begin
               rm_ff    <= rf_rval;
               state_ff <= ST_RDN;
            end
            ST_RDN: begin
               rn_ff    <= rf_rval;
               state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               res_wr_ff    <= rf_we;
               res_val_ff   <= alu_val;
               res_drop_ff  <= 1'b0;
               res_fault_ff <= (push_op && !stk_we) || (pop_op && !pop_ok);
               pc_ff        <= pc_ff + step;
               state_ff     <= exec_next;
               if (!halt_ff) begin
                  unique case (op)
                     OP_HALT: halt_ff <= 1'b1;
                     OP_CTRL: begin
                        if (!instr_ff[11]) begin
                           case (sub)
                              SUB_PUSH: begin
                                 if (stk_we) begin
                                    stk_cnt_ff <= stk_cnt_ff + SAW'(1);
                                 end
                              end
                              SUB_POP: begin
                                 if (pop_ok) begin
                                    stk_cnt_ff <= stk_cnt_ff - SAW'(1);
                                 end
                              end
                              SUB_CMP: begin
                                 flags_ff <= {sum[16], rm_ff < rn_ff, rm_ff < rn_ff,
                                              rm_ff == rn_ff};
                              end
                              default: ;
                           endcase
                        end
                     end
                     OP_STORE, OP_LOAD: begin
                        iss_ff     <= '0;
                        chk_vld_ff <= 1'b0;
                     end
                     OP_MUL: begin
                        mul_acc_ff <= 16'd0;
                        mul_a_ff   <= rm_ff;
                        mul_b_ff   <= rn_ff;
                        mul_cnt_ff <= 4'd0;
                     end
                     default: ;
                  endcase
               end
            end
            ST_MUL: begin
               mul_acc_ff <= mul_res;
               mul_a_ff   <= mul_a_ff << 1;
               mul_b_ff   <= mul_b_ff >> 1;
               mul_cnt_ff <= mul_cnt_ff + 4'd1;
               if (mul_cnt_ff == 4'd15) begin
                  res_wr_ff  <= 1'b1;
                  res_val_ff <= mul_res;
                  state_ff   <= ST_FIN;
               end
            end
            ST_SCAN: begin
               if (key_hit) begin
                  chk_vld_ff <= 1'b0;
                  state_ff   <= (op == OP_STORE) ? ST_FIN : ST_LDWB;
               end else if (scan_miss) begin
                  if (op == OP_STORE) begin
                     if (store_room) begin
                        mem_cnt_ff <= mem_cnt_ff + CW'(1);
                     end else begin
                        res_drop_ff <= 1'b1;
                     end
                  end
                  state_ff <= ST_FIN;
               end else if (iss_ff != mem_cnt_ff) begin
                  chk_vld_ff <= 1'b1;
                  chk_idx_ff <= iss_ff[AW-1:0];
                  iss_ff     <= iss_ff + CW'(1);
               end else begin
                  chk_vld_ff <= 1'b0;
               end
            end
            ST_LDWB: begin
               res_wr_ff  <= 1'b1;
               res_val_ff <= val_rdata;
               state_ff   <= ST_FIN;
            end
            ST_POPWB: begin
               res_wr_ff  <= 1'b1;
               res_val_ff <= stk_rdata;
               state_ff   <= ST_FIN;
            end
            ST_FIN: begin
               // result register frees when empty or taken this cycle
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_next_pc       <= pc_ff;
                  rsp_halted        <= halt_ff;
                  rsp_reg_written   <= res_wr_ff;
                  rsp_reg_index     <= res_wr_ff ? rd : 3'd0;
                  rsp_reg_value     <= res_wr_ff ? res_val_ff : 16'd0;
                  rsp_flag_zero     <= flags_ff[0];
                  rsp_flag_carry    <= flags_ff[1];
                  rsp_flag_sign     <= flags_ff[2];
                  rsp_flag_overflow <= flags_ff[3];
                  rsp_store_dropped <= res_drop_ff;
                  rsp_stack_fault   <= res_fault_ff;
                  state_ff          <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `SBCE_ASSERT_NXT(a_busy_after_beat, clock, reset, req_valid && req_ready, !req_ready, "ready high right after an accepted beat")
   `SBCE_ASSERT_NXT(a_halt_sticks, clock, reset, halt_ff, halt_ff, "halt cleared without reset")
   `SBCE_ASSERT_IMP(a_halt_no_write, clock, reset, rsp_valid && rsp_halted, !rsp_reg_written, "register written while halted")
   `SBCE_ASSERT_IMP(a_store_bound, clock, reset, 1'b1, mem_cnt_ff <= CW'(STORE_ENTRIES), "store count past capacity")
   `SBCE_ASSERT_IMP(a_stack_bound, clock, reset, stk_we, stk_cnt_ff != SAW'(STACK_DEPTH - 1), "push written to a full stack")

endmodule
